>>> rtl/line_sensor_pd_steering_macros.svh
// assertion macros for the line sensor pd steering block
// used by modules that check their own control logic, no dependencies
`ifndef LINE_SENSOR_PD_STEERING_MACROS_SVH
`define LINE_SENSOR_PD_STEERING_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define LSPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define LSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lsps_pkg.sv
// package for the line sensor pd steering block
// types, register codes, reset values and sensor weights; no dependencies
package lsps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUT = 3'd3;

    localparam logic signed [15:0] PROP_GAIN_RST    = 16'sd256;
    localparam logic signed [15:0] DERIV_GAIN_RST   = 16'sd0;
    localparam logic [14:0]        OUTPUT_LIMIT_RST = 15'd32767;

    localparam logic signed [6:0] SENSOR_WEIGHT [8] = '{
        -7'sd35, -7'sd25, -7'sd15, -7'sd5, 7'sd5, 7'sd15, 7'sd25, 7'sd35
    };

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] deriv_gain;
        logic [14:0]        output_limit;
        logic               invert_output;
    } t_cfg;

    // classified sample: sign and magnitude of the weight sum, set-bit count
    typedef struct packed {
        logic       neg;
        logic [7:0] mag;
        logic [3:0] cnt;
    } t_cls;

endpackage

>>> rtl/lsps_if.sv
// valid/ready channel interfaces for sensor samples and steering results
// no dependencies
interface lsps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sensor_bits;

    modport source(output valid, output sensor_bits, input ready);
    modport sink(input valid, input sensor_bits, output ready);
endinterface

interface lsps_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] steer_correction;
    logic               line_valid;
    logic signed [6:0]  position_error;

    modport source(output valid, output steer_correction, output line_valid,
                   output position_error, input ready);
    modport sink(input valid, input steer_correction, input line_valid,
                 input position_error, output ready);
endinterface

>>> rtl/lsps_front.sv
// front end: accepts sensor samples and forms weight sum and set-bit count
// depends on lsps_pkg and lsps_in_if
module lsps_front (
    lsps_in_if.sink        in_if,
    input  logic           i_full,
    output logic           o_push,
    output lsps_pkg::t_cls o_cls
);

    logic signed [8:0] sum;
    logic [3:0]        cnt;

    always_comb begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < 8; i++) begin
            if (in_if.sensor_bits[i]) begin
                sum = sum + 9'(lsps_pkg::SENSOR_WEIGHT[i]);
                cnt = cnt + 4'd1;
            end
        end
    end

    assign in_if.ready = !i_full;
    assign o_push      = in_if.valid && !i_full;
    assign o_cls.neg   = sum[8];
    assign o_cls.mag   = sum[8] ? 8'(-sum) : sum[7:0];
    assign o_cls.cnt   = cnt;

endmodule

>>> rtl/lsps_queue.sv
// short queue between front and back end, held in flip-flops
// depends on lsps_pkg
module lsps_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsps_pkg::t_cls i_data,
    input  logic           i_pop,
    output lsps_pkg::t_cls o_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lsps_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + PW'(1);
        end
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/lsps_back.sv
// back end: divides weight sum by count, forms pd term, inverts and clamps
// depends on lsps_pkg, lsps_out_if and the assertion macros header
`include "line_sensor_pd_steering_macros.svh"

module lsps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsps_pkg::t_cfg i_cfg,
    input  lsps_pkg::t_cls i_cls,
    input  logic           i_empty,
    output logic           o_pop,
    lsps_out_if.source     out_if
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_step;

    logic [7:0] r_dvd;
    logic [3:0] r_dvs;
    logic [3:0] r_rem;
    logic [7:0] r_quo;
    logic       r_neg;
    logic       r_vld;

    logic signed [6:0]  r_prev;
    logic               r_seen;
    logic signed [6:0]  r_err;
    logic signed [7:0]  r_deriv;
    logic signed [22:0] r_p1;
    logic signed [23:0] r_p2;
    logic signed [16:0] r_corr;

    logic               r_ovalid;
    logic signed [15:0] r_o_steer;
    logic               r_o_lv;
    logic signed [6:0]  r_o_err;

    logic [4:0]         s1;
    logic [4:0]         s2;
    logic signed [6:0]  q_signed;
    logic signed [6:0]  n_err;
    logic signed [7:0]  n_deriv;
    logic signed [24:0] total;
    logic signed [24:0] total_b;
    logic signed [24:0] shifted;
    logic signed [16:0] c_inv;
    logic signed [16:0] lim;
    logic signed [16:0] c_clamp;
    logic               out_load;

    function automatic logic [4:0] div_step(input logic [3:0] rem, input logic din,
                                            input logic [3:0] dvs);
        logic [4:0] t;
        begin
            t = {rem, din};
            if (t >= {1'b0, dvs}) begin
                div_step = {1'b1, 4'(t - {1'b0, dvs})};
            end else begin
                div_step = {1'b0, t[3:0]};
            end
        end
    endfunction

    // two quotient bits per cycle
    assign s1 = div_step(r_rem, r_dvd[7], r_dvs);
    assign s2 = div_step(s1[3:0], r_dvd[6], r_dvs);

    assign q_signed = r_neg ? -$signed(r_quo[6:0]) : $signed(r_quo[6:0]);

    always_comb begin
        if (r_vld) begin
            n_err = q_signed;
        end else if (r_seen) begin
            n_err = r_prev;
        end else begin
            n_err = '0;
        end
    end

    assign n_deriv = {n_err[6], n_err} - {r_prev[6], r_prev};

    // truncate toward zero on the divide by 256
    assign total   = 25'(r_p1) + 25'(r_p2);
    assign total_b = total + (total[24] ? 25'sd255 : 25'sd0);
    assign shifted = total_b >>> 8;

    assign c_inv = i_cfg.invert_output ? -r_corr : r_corr;
    assign lim   = $signed({2'b00, i_cfg.output_limit});

    always_comb begin
        if (c_inv > lim) begin
            c_clamp = lim;
        end else if (c_inv < -lim) begin
            c_clamp = -lim;
        end else begin
            c_clamp = c_inv;
        end
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || out_if.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_cls.cnt == '0) ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == 2'd3) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_prev   <= '0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= '0;
            end
            if (r_state == S_ERR) begin
                r_prev <= n_err;
                if (r_vld) begin
                    r_seen <= 1'b1;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (out_if.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dvd <= i_cls.mag;
                r_dvs <= i_cls.cnt;
                r_neg <= i_cls.neg;
                r_vld <= (i_cls.cnt != '0);
                r_rem <= '0;
                r_quo <= '0;
            end
            S_DIV: begin
                r_dvd <= {r_dvd[5:0], 2'b00};
                r_rem <= s2[3:0];
                r_quo <= {r_quo[5:0], s1[4], s2[4]};
            end
            S_ERR: begin
                r_err   <= n_err;
                r_deriv <= n_deriv;
            end
            S_MUL: begin
                r_p1 <= 23'($signed(i_cfg.prop_gain)) * 23'(r_err);
                r_p2 <= 24'($signed(i_cfg.deriv_gain)) * 24'(r_deriv);
            end
            S_SUM: begin
                r_corr <= shifted[16:0];
            end
            S_OUT: begin
                if (out_load) begin
                    r_o_steer <= c_clamp[15:0];
                    r_o_lv    <= r_vld;
                    r_o_err   <= r_err;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_if.valid            = r_ovalid;
    assign out_if.steer_correction = r_o_steer;
    assign out_if.line_valid       = r_o_lv;
    assign out_if.position_error   = r_o_err;

    `LSPS_ASSERT_IMPL(a_err_range, i_clk, i_rst_n, r_ovalid, (r_o_err >= -7'sd35) && (r_o_err <= 7'sd35), "position error out of range")
    `LSPS_ASSERT_IMPL(a_steer_limit, i_clk, i_rst_n, r_ovalid, ($signed({r_o_steer[15], r_o_steer}) <= lim) && ($signed({r_o_steer[15], r_o_steer}) >= -lim), "steer correction beyond limit")
    `LSPS_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dvs != 4'd0, "divide by zero count")
    `LSPS_ASSERT_NEXT(a_pop_to_work, i_clk, i_rst_n, o_pop, (r_state == S_DIV) || (r_state == S_ERR), "popped sample not processed")

endmodule

>>> rtl/line_sensor_pd_steering.sv
// line sensor pd steering controller: from accept, a sample passes the queue, then a
// two-bit-per-cycle divider (skipped when no sensor bit is set), then error, pd
// multiply, sum and clamp steps before its result is registered as valid; the back end
// starts the next sample only once that result is loaded, which an output stall can
// delay; a short queue lets the front accept while busy
// synchronous active-low reset clears gains to defaults, error history and queue
module line_sensor_pd_steering #(
    parameter int QDEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lsps_in_if.sink                         in_if,
    lsps_out_if.source                      out_if,
    input  logic                            i_cfg_we,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lsps_pkg::t_cfg r_cfg;
    lsps_pkg::t_cls push_cls;
    lsps_pkg::t_cls head_cls;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= lsps_pkg::PROP_GAIN_RST;
            r_cfg.deriv_gain    <= lsps_pkg::DERIV_GAIN_RST;
            r_cfg.output_limit  <= lsps_pkg::OUTPUT_LIMIT_RST;
            r_cfg.invert_output <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsps_pkg::CFG_PROP_GAIN:     r_cfg.prop_gain     <= $signed(i_cfg_data);
                lsps_pkg::CFG_DERIV_GAIN:    r_cfg.deriv_gain    <= $signed(i_cfg_data);
                lsps_pkg::CFG_OUTPUT_LIMIT:  r_cfg.output_limit  <= i_cfg_data[14:0];
                lsps_pkg::CFG_INVERT_OUTPUT: r_cfg.invert_output <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lsps_front u_front (
        .in_if  (in_if),
        .i_full (full),
        .o_push (push),
        .o_cls  (push_cls)
    );

    lsps_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .i_pop   (pop),
        .o_data  (head_cls),
        .o_full  (full),
        .o_empty (empty)
    );

    lsps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cls   (head_cls),
        .i_empty (empty),
        .o_pop   (pop),
        .out_if  (out_if)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for line_sensor_pd_steering: directed table, then random samples
// under three handshake idling mixes; depends on lsps_pkg, lsps_if and the rtl top level
module tb_top;

    typedef struct packed {
        logic signed [15:0] steer;
        logic               line_valid;
        logic signed [6:0]  perr;
    } t_steer_result;

    typedef struct {
        bit                              is_reg;
        logic [lsps_pkg::CFG_IDX_W-1:0]  idx;
        logic [lsps_pkg::CFG_DATA_W-1:0] data;
        logic [7:0]                      bits;
        bit                              known;
        t_steer_result                   res;
    } t_stim_row;

    localparam int SEGMENTS     = 5;
    localparam int SEG_SAMPLES  = 130;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO =
        lsps_pkg::CFG_INVERT_OUTPUT + 1'b1;
    localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
    localparam int TRACK_WEIGHT [8] = '{-35, -25, -15, -5, 5, 15, 25, 35};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [lsps_pkg::CFG_DATA_W-1:0] cfg_data;

    lsps_in_if  sample_ch ();
    lsps_out_if steer_ch ();

    line_sensor_pd_steering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (sample_ch),
        .out_if     (steer_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and register copy
    int kp_gain;
    int kd_gain;
    int clamp_lim;
    bit negate_out;
    int last_err;
    bit line_seen;

    t_steer_result steer_q [$];
    t_stim_row     stim_rows [$];
    int miss_cnt;
    int send_idle_pct;
    int recv_idle_pct;

    function automatic void apply_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                                      logic [lsps_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsps_pkg::CFG_PROP_GAIN:     kp_gain = $signed(data[15:0]);
            lsps_pkg::CFG_DERIV_GAIN:    kd_gain = $signed(data[15:0]);
            lsps_pkg::CFG_OUTPUT_LIMIT:  clamp_lim = int'(data[14:0]);
            lsps_pkg::CFG_INVERT_OUTPUT: negate_out = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_steer_result pd_predict(logic [7:0] bits);
        int sum;
        int cnt;
        int err;
        int corr;
        t_steer_result r;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < 8; i++) begin
            if (bits[i]) begin
                sum += TRACK_WEIGHT[i];
                cnt++;
            end
        end
        if (cnt > 0) begin
            line_seen = 1'b1;
            err = sum / cnt;
        end else if (line_seen) begin
            err = last_err;
        end else begin
            err = 0;
        end
        corr = (kp_gain * err + kd_gain * (err - last_err)) / 256;
        if (negate_out)
            corr = -corr;
        if (corr > clamp_lim)
            corr = clamp_lim;
        else if (corr < -clamp_lim)
            corr = -clamp_lim;
        last_err = err;
        r.steer = corr[15:0];
        r.line_valid = (cnt > 0);
        r.perr = err[6:0];
        return r;
    endfunction

    task automatic report_miss(string what, t_steer_result want, t_steer_result got);
        miss_cnt++;
        if (miss_cnt <= MAX_REPORTS)
            $display("%0t %s: expected steer %0d valid %0d err %0d, got steer %0d valid %0d err %0d",
                     $realtime, what, want.steer, want.line_valid, want.perr,
                     got.steer, got.line_valid, got.perr);
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_steer_result want;
        t_steer_result got;
        if (i_rst_n && steer_ch.valid && steer_ch.ready) begin
            got.steer = steer_ch.steer_correction;
            got.line_valid = steer_ch.line_valid;
            got.perr = steer_ch.position_error;
            if (steer_q.size() == 0) begin
                report_miss("unexpected transaction", '0, got);
            end else begin
                want = steer_q.pop_front();
                if (got.steer !== want.steer || got.line_valid !== want.line_valid ||
                    got.perr !== want.perr)
                    report_miss("steering mismatch", want, got);
            end
        end
    end

    always @(negedge i_clk)
        steer_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_sample(logic [7:0] bits, bit known, t_steer_result typed);
        t_steer_result r;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sensor_bits <= bits;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        r = pd_predict(bits);
        steer_q.push_back(known ? typed : r);
    endtask

    task automatic settle_pipeline();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        while (steer_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                             logic [lsps_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lsps_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        row.bits = '0;
        row.known = 1'b0;
        row.res = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_sample(logic [7:0] bits, bit known, logic signed [15:0] steer,
                                       logic lv, logic signed [6:0] perr);
        t_stim_row row;
        row.is_reg = 1'b0;
        row.idx = '0;
        row.data = '0;
        row.bits = bits;
        row.known = known;
        row.res.steer = steer;
        row.res.line_valid = lv;
        row.res.perr = perr;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h0100;
            4: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1: return 8'h00;
            2: return 8'h01 << $urandom_range(0, 7);
            3: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic load_random_regs();
        logic [15:0] lim_w;
        case ($urandom_range(0, 3))
            0: lim_w = 16'h0000;
            1: lim_w = 16'h7fff;
            2: lim_w = 16'($urandom_range(1, 64));
            default: lim_w = 16'($urandom_range(0, 32767));
        endcase
        lim_w[15] = 1'($urandom_range(0, 1));
        write_reg(lsps_pkg::CFG_PROP_GAIN, pick_gain());
        write_reg(lsps_pkg::CFG_DERIV_GAIN, pick_gain());
        write_reg(lsps_pkg::CFG_OUTPUT_LIMIT, lim_w);
        write_reg(lsps_pkg::CFG_INVERT_OUTPUT, 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_reg(lsps_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      16'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sensor_bits = '0;
        miss_cnt = 0;
        send_idle_pct = 16;
        recv_idle_pct = 71;
        kp_gain = lsps_pkg::PROP_GAIN_RST;
        kd_gain = lsps_pkg::DERIV_GAIN_RST;
        clamp_lim = lsps_pkg::OUTPUT_LIMIT_RST;
        negate_out = 1'b0;
        last_err = 0;
        line_seen = 1'b0;

        // reset defaults: unity proportional gain, no derivative, full limit
        add_sample(8'h00, 1, 0, 0, 0);
        add_sample(8'h01, 1, -35, 1, -35);
        add_sample(8'h00, 1, -35, 0, -35);
        add_sample(8'h80, 1, 35, 1, 35);
        add_sample(8'hff, 1, 0, 1, 0);
        add_sample(8'h0b, 1, -21, 1, -21);
        add_sample(8'hd0, 1, 21, 1, 21);
        add_reg(lsps_pkg::CFG_DERIV_GAIN, 16'h0100);
        add_sample(8'h01, 0, 0, 0, 0);
        add_sample(8'h00, 0, 0, 0, 0);
        add_sample(8'h80, 0, 0, 0, 0);
        add_reg(lsps_pkg::CFG_PROP_GAIN, 16'h7fff);
        add_reg(lsps_pkg::CFG_DERIV_GAIN, 16'h7fff);
        add_sample(8'h01, 0, 0, 0, 0);
        add_sample(8'h80, 0, 0, 0, 0);
        add_reg(lsps_pkg::CFG_PROP_GAIN, 16'h8000);
        add_reg(lsps_pkg::CFG_DERIV_GAIN, 16'h8000);
        add_sample(8'h01, 0, 0, 0, 0);
        add_sample(8'h80, 0, 0, 0, 0);
        add_sample(8'h00, 0, 0, 0, 0);
        add_reg(lsps_pkg::CFG_INVERT_OUTPUT, 16'h0001);
        add_sample(8'h01, 0, 0, 0, 0);
        add_sample(8'h80, 0, 0, 0, 0);
        // zero limit pins the correction to zero
        add_reg(lsps_pkg::CFG_OUTPUT_LIMIT, 16'h0000);
        add_sample(8'h01, 1, 0, 1, -35);
        add_sample(8'hff, 1, 0, 1, 0);
        add_reg(lsps_pkg::CFG_OUTPUT_LIMIT, 16'd100);
        add_sample(8'h80, 0, 0, 0, 0);
        add_sample(8'h01, 0, 0, 0, 0);
        // write to an unused index must leave all gains alone
        add_reg(CFG_SPARE_HI, 16'h0000);
        add_sample(8'h03, 0, 0, 0, 0);
        add_reg(lsps_pkg::CFG_INVERT_OUTPUT, 16'h0000);
        add_reg(lsps_pkg::CFG_OUTPUT_LIMIT, 16'h7fff);
        add_reg(lsps_pkg::CFG_PROP_GAIN, 16'h0100);
        add_reg(lsps_pkg::CFG_DERIV_GAIN, 16'h0000);
        add_sample(8'h80, 1, 35, 1, 35);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_reg) begin
                settle_pipeline();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_sample(stim_rows[i].bits, stim_rows[i].known, stim_rows[i].res);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 16 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                settle_pipeline();
                load_random_regs();
                for (int n = 0; n < SEG_SAMPLES; n++) begin
                    send_sample(pick_sample(), 0, '0);
                    if ($urandom_range(0, 99) == 0)
                        settle_pipeline();
                end
            end
        end

        settle_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (miss_cnt == 0 && steer_q.size() == 0) begin
            $display("line_sensor_pd_steering verification clean");
        end else begin
            $display("line_sensor_pd_steering verification failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("line_sensor_pd_steering verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/lsps_pkg.sv
rtl/lsps_if.sv
rtl/lsps_front.sv
rtl/lsps_queue.sv
rtl/lsps_back.sv
rtl/line_sensor_pd_steering.sv
test/tb_top.sv
